// ===== hw/rtl/ray_box_slab_intersection_assert.svh =====
// assertion macros for the ray box slab test
`ifndef RAY_BOX_SLAB_INTERSECTION_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECTION_ASSERT_SVH

// same-cycle implication under synchronous reset
`define RBSI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous reset
`define RBSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rbsi_pkg.sv =====
package rbsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int EPS_W       = 31;
  localparam int NUM_W       = COORD_WIDTH + 1 + FRAC_BITS;
  localparam int CMP_W       = (COORD_WIDTH > EPS_W) ? COORD_WIDTH : EPS_W;
  localparam int LANE_ST     = COORD_WIDTH + 2;
  localparam int PIPE_ST     = LANE_ST + 1;
  localparam int NUM_AXES    = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [EPS_W-1:0] eps_t;

  localparam coord_t T_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t T_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [COORD_WIDTH-1:0] rem;
    logic [COORD_WIDTH-1:0] w;
  } div_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] dmag;
    logic                   neg_lo;
    logic                   neg_hi;
    logic                   ovf_lo;
    logic                   ovf_hi;
    logic                   par;
    logic                   ok;
  } meta_t;

  typedef struct packed {
    logic   par;
    logic   ok;
    coord_t tmin;
    coord_t tmax;
  } lane_res_t;

  // one restoring step, one quotient bit
  function automatic div_t div_step(div_t x, logic [COORD_WIDTH-1:0] dv);
    logic [COORD_WIDTH:0] t;
    logic                 q;
    div_t                 r;
    t = {x.rem, x.w[COORD_WIDTH-1]};
    q = (t >= {1'b0, dv});
    if (q) begin
      t = t - {1'b0, dv};
    end
    r.rem = t[COORD_WIDTH-1:0];
    r.w   = {x.w[COORD_WIDTH-2:0], q};
    return r;
  endfunction

  // apply sign and clamp to the coordinate range
  function automatic coord_t sat_q(logic [COORD_WIDTH-1:0] qm, logic neg, logic ovf);
    coord_t r;
    if (neg) begin
      if (ovf || (qm > {1'b1, {(COORD_WIDTH-1){1'b0}}})) begin
        r = T_MIN;
      end else begin
        r = coord_t'(~qm + 1'b1);
      end
    end else begin
      if (ovf || qm[COORD_WIDTH-1]) begin
        r = T_MAX;
      end else begin
        r = coord_t'(qm);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ray_box_slab_intersection.sv =====
// channel   | handshake           | payload
// ----------+---------------------+-------------------------------------------
// in        | in_valid / in_stall | in_origin_*, in_dir_*, in_box_lo_*, in_box_hi_*
// out       | out_valid/out_stall | out_hit, out_t_near, out_t_far
// cfg       | cfg_wr_en           | cfg_wr_data (parallel epsilon)
//
// one request accepted per cycle while in_stall is low; each accepted request passes
// through preparation, 32 restoring division steps per lane, saturate/order and merge
// synchronous active-low reset empties the pipeline and sets epsilon to 1
// a stalled output only holds stages that are full: bubbles still close up
`include "ray_box_slab_intersection_assert.svh"

module ray_box_slab_intersection (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  rbsi_pkg::eps_t             cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  rbsi_pkg::coord_t           in_origin_x,
  input  rbsi_pkg::coord_t           in_origin_y,
  input  rbsi_pkg::coord_t           in_origin_z,
  input  rbsi_pkg::coord_t           in_dir_x,
  input  rbsi_pkg::coord_t           in_dir_y,
  input  rbsi_pkg::coord_t           in_dir_z,
  input  rbsi_pkg::coord_t           in_box_lo_x,
  input  rbsi_pkg::coord_t           in_box_lo_y,
  input  rbsi_pkg::coord_t           in_box_lo_z,
  input  rbsi_pkg::coord_t           in_box_hi_x,
  input  rbsi_pkg::coord_t           in_box_hi_y,
  input  rbsi_pkg::coord_t           in_box_hi_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output rbsi_pkg::coord_t           out_t_near,
  output rbsi_pkg::coord_t           out_t_far
);

  localparam int NST = rbsi_pkg::PIPE_ST;

  rbsi_pkg::eps_t      eps_r;
  logic [NST-1:0]      v_r, v_nxt, rdy;
  rbsi_pkg::coord_t    o_a [rbsi_pkg::NUM_AXES];
  rbsi_pkg::coord_t    d_a [rbsi_pkg::NUM_AXES];
  rbsi_pkg::coord_t    lo_a [rbsi_pkg::NUM_AXES];
  rbsi_pkg::coord_t    hi_a [rbsi_pkg::NUM_AXES];
  rbsi_pkg::lane_res_t res [rbsi_pkg::NUM_AXES];

  assign o_a  = '{in_origin_x, in_origin_y, in_origin_z};
  assign d_a  = '{in_dir_x, in_dir_y, in_dir_z};
  assign lo_a = '{in_box_lo_x, in_box_lo_y, in_box_lo_z};
  assign hi_a = '{in_box_hi_x, in_box_hi_y, in_box_hi_z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= rbsi_pkg::eps_t'(1);
    end else if (cfg_wr_en) begin
      eps_r <= cfg_wr_data;
    end
  end

  // a stage may load unless it and every stage after it are full and the output is held
  always_comb begin
    for (int i = 0; i < NST; i++) begin
      rdy[i] = !(out_stall && (&(v_r | ((NST'(1) << i) - NST'(1)))));
    end
    for (int i = 0; i < NST; i++) begin
      if (rdy[i]) begin
        v_nxt[i] = (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i-1];
      end else begin
        v_nxt[i] = v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  for (genvar a = 0; a < rbsi_pkg::NUM_AXES; a++) begin : g_lane
    rbsi_lane u_lane (
      .clk (clk),
      .en  (rdy[rbsi_pkg::LANE_ST-1:0]),
      .eps (eps_r),
      .o   (o_a[a]),
      .d   (d_a[a]),
      .lo  (lo_a[a]),
      .hi  (hi_a[a]),
      .res (res[a])
    );
  end

  rbsi_merge u_merge (
    .clk    (clk),
    .en     (rdy[NST-1]),
    .res    (res),
    .hit    (out_hit),
    .t_near (out_t_near),
    .t_far  (out_t_far)
  );

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NST-1];

  `RBSI_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v_r[0], "accepted request lost")
  `RBSI_ASSERT_SAME(a_bubble_accept, !v_r[0], !in_stall, "empty first stage refuses request")
  `RBSI_ASSERT_NEXT(a_last_to_out, v_r[NST-2] && rdy[NST-1], out_valid, "result lost at merge")

endmodule

// ===== hw/rtl/rbsi_lane.sv =====
module rbsi_lane (
  input  logic                         clk,
  input  logic [rbsi_pkg::LANE_ST-1:0] en,
  input  rbsi_pkg::eps_t               eps,
  input  rbsi_pkg::coord_t             o,
  input  rbsi_pkg::coord_t             d,
  input  rbsi_pkg::coord_t             lo,
  input  rbsi_pkg::coord_t             hi,
  output rbsi_pkg::lane_res_t          res
);

  localparam int CW = rbsi_pkg::COORD_WIDTH;
  localparam int FB = rbsi_pkg::FRAC_BITS;
  localparam int NW = rbsi_pkg::NUM_W;

  logic signed [CW:0]      dl, dh;
  logic [CW:0]             ml, mh;
  logic [NW-1:0]           nl, nh;
  logic [CW-1:0]           dmag;
  rbsi_pkg::meta_t         meta_nxt;
  rbsi_pkg::div_t          dlo_nxt, dhi_nxt;

  rbsi_pkg::meta_t         meta_r  [CW+1];
  rbsi_pkg::div_t          dlo_r   [CW+1];
  rbsi_pkg::div_t          dhi_r   [CW+1];
  rbsi_pkg::lane_res_t     res_r;
  rbsi_pkg::coord_t        ta, tb;

  always_comb begin
    dl   = $signed({lo[CW-1], lo}) - $signed({o[CW-1], o});
    dh   = $signed({hi[CW-1], hi}) - $signed({o[CW-1], o});
    ml   = dl[CW] ? (~dl + 1'b1) : dl;
    mh   = dh[CW] ? (~dh + 1'b1) : dh;
    nl   = {ml, {FB{1'b0}}};
    nh   = {mh, {FB{1'b0}}};
    dmag = d[CW-1] ? (~d + 1'b1) : d;
    meta_nxt.dmag   = dmag;
    meta_nxt.neg_lo = dl[CW] ^ d[CW-1];
    meta_nxt.neg_hi = dh[CW] ^ d[CW-1];
    meta_nxt.ovf_lo = (nl >> CW) >= NW'(dmag);
    meta_nxt.ovf_hi = (nh >> CW) >= NW'(dmag);
    meta_nxt.par    = (d == '0) ||
                      (rbsi_pkg::CMP_W'(dmag) < rbsi_pkg::CMP_W'(eps));
    meta_nxt.ok     = (o >= lo) && (o <= hi);
    dlo_nxt.rem = CW'(nl >> CW);
    dlo_nxt.w   = nl[CW-1:0];
    dhi_nxt.rem = CW'(nh >> CW);
    dhi_nxt.w   = nh[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      meta_r[0] <= meta_nxt;
      dlo_r[0]  <= dlo_nxt;
      dhi_r[0]  <= dhi_nxt;
    end
  end

  for (genvar k = 1; k <= CW; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en[k]) begin
        meta_r[k] <= meta_r[k-1];
        dlo_r[k]  <= rbsi_pkg::div_step(dlo_r[k-1], meta_r[k-1].dmag);
        dhi_r[k]  <= rbsi_pkg::div_step(dhi_r[k-1], meta_r[k-1].dmag);
      end
    end
  end

  always_comb begin
    ta = rbsi_pkg::sat_q(dlo_r[CW].w, meta_r[CW].neg_lo, meta_r[CW].ovf_lo);
    tb = rbsi_pkg::sat_q(dhi_r[CW].w, meta_r[CW].neg_hi, meta_r[CW].ovf_hi);
  end

  always_ff @(posedge clk) begin
    if (en[CW+1]) begin
      res_r.par  <= meta_r[CW].par;
      res_r.ok   <= meta_r[CW].ok;
      res_r.tmin <= (ta > tb) ? tb : ta;
      res_r.tmax <= (ta > tb) ? ta : tb;
    end
  end

  assign res = res_r;

endmodule

// ===== hw/rtl/rbsi_merge.sv =====
module rbsi_merge (
  input  logic                clk,
  input  logic                en,
  input  rbsi_pkg::lane_res_t res [rbsi_pkg::NUM_AXES],
  output logic                hit,
  output rbsi_pkg::coord_t    t_near,
  output rbsi_pkg::coord_t    t_far
);

  logic             hit_r, hit_nxt;
  rbsi_pkg::coord_t tn_r, tn_nxt, tf_r, tf_nxt;
  logic             done;

  // slabs in order x, y, z, stop at the first miss
  always_comb begin
    tn_nxt  = rbsi_pkg::T_MIN;
    tf_nxt  = rbsi_pkg::T_MAX;
    hit_nxt = 1'b1;
    done    = 1'b0;
    for (int a = 0; a < rbsi_pkg::NUM_AXES; a++) begin
      if (!done) begin
        if (res[a].par) begin
          if (!res[a].ok) begin
            hit_nxt = 1'b0;
            done    = 1'b1;
          end
        end else begin
          if (res[a].tmin > tn_nxt) begin
            tn_nxt = res[a].tmin;
          end
          if (res[a].tmax < tf_nxt) begin
            tf_nxt = res[a].tmax;
          end
          if (tn_nxt > tf_nxt) begin
            hit_nxt = 1'b0;
            done    = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
      tn_r  <= tn_nxt;
      tf_r  <= tf_nxt;
    end
  end

  assign hit    = hit_r;
  assign t_near = tn_r;
  assign t_far  = tf_r;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rbsi_pkg::*;

  typedef struct {
    coord_t org [3];
    coord_t dir [3];
    coord_t lo [3];
    coord_t hi [3];
  } ray_box_t;

  typedef struct {
    logic   hit;
    coord_t t_near;
    coord_t t_far;
  } slab_res_t;

  int err_count = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  class slab_scoreboard;
    eps_t      epsilon = 1;
    slab_res_t pending[$];

    function longint plane_t(longint bound, longint o, longint d);
      longint q;
      q = ((bound - o) * 65536) / d;
      if (q > longint'(T_MAX)) q = T_MAX;
      if (q < longint'(T_MIN)) q = T_MIN;
      return q;
    endfunction

    function void note_request(ray_box_t r);
      longint    tn, tf, o, d, l, h, t1, t2, s, mag;
      slab_res_t e;
      tn = T_MIN;
      tf = T_MAX;
      e.hit = 1;
      for (int a = 0; a < 3; a++) begin
        o = r.org[a]; d = r.dir[a]; l = r.lo[a]; h = r.hi[a];
        mag = (d < 0) ? -d : d;
        if (d == 0 || mag < longint'(epsilon)) begin
          if (o < l || o > h) begin
            e.hit = 0;
            break;
          end
        end else begin
          t1 = plane_t(l, o, d);
          t2 = plane_t(h, o, d);
          if (t1 > t2) begin s = t1; t1 = t2; t2 = s; end
          if (t1 > tn) tn = t1;
          if (t2 < tf) tf = t2;
          if (tn > tf) begin
            e.hit = 0;
            break;
          end
        end
      end
      e.t_near = coord_t'(tn);
      e.t_far  = coord_t'(tf);
      pending.push_back(e);
    endfunction

    task check_result(logic hit, coord_t tn, coord_t tf);
      slab_res_t e;
      if (pending.size() == 0) begin
        report("unexpected result", hit, 0);
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) report("hit", hit, e.hit);
      if (tn !== e.t_near) report("t_near", tn, e.t_near);
      if (tf !== e.t_far) report("t_far", tf, e.t_far);
    endtask
  endclass

  slab_scoreboard sb = new();

  logic   clk = 0;
  logic   rst_n = 0;
  logic   cfg_wr_en = 0;
  eps_t   cfg_wr_data = '0;
  logic   in_valid = 0;
  logic   in_stall;
  coord_t in_f [12] = '{default: '0};
  logic   out_valid;
  logic   out_stall = 1;
  logic   out_hit;
  coord_t out_t_near, out_t_far;
  bit     hold_off = 0;
  bit     long_hold_req = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  ray_box_slab_intersection u_dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_stall,
    .in_origin_x(in_f[0]), .in_origin_y(in_f[1]), .in_origin_z(in_f[2]),
    .in_dir_x(in_f[3]), .in_dir_y(in_f[4]), .in_dir_z(in_f[5]),
    .in_box_lo_x(in_f[6]), .in_box_lo_y(in_f[7]), .in_box_lo_z(in_f[8]),
    .in_box_hi_x(in_f[9]), .in_box_hi_y(in_f[10]), .in_box_hi_z(in_f[11]),
    .out_valid, .out_stall, .out_hit, .out_t_near, .out_t_far
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_hit, out_t_near, out_t_far);
  end

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1;
        repeat (200) @(posedge clk);
        long_hold_req = 0;
      end
      n = hold_off ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) n = 0;
      out_stall <= (n != 0);
      repeat (n) @(posedge clk);
      out_stall <= 0;
      @(posedge clk iff out_valid);
    end
  end

  task automatic send(ray_box_t r, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (!no_gap && $urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    for (int i = 0; i < 3; i++) begin
      in_f[i] <= r.org[i]; in_f[3+i] <= r.dir[i];
      in_f[6+i] <= r.lo[i]; in_f[9+i] <= r.hi[i];
    end
    @(posedge clk iff !in_stall);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_epsilon(eps_t v);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.epsilon = v;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
      2: return $urandom_range(0, 1) ? T_MAX : T_MIN;
      3: return coord_t'($signed($urandom_range(0, 8)) - 4);
      default: return coord_t'($signed($urandom_range(0, 32'h01000000)) - 32'sh00800000);
    endcase
  endfunction

  function automatic ray_box_t rand_ray(bit shaped);
    ray_box_t r;
    coord_t   a, b;
    for (int i = 0; i < 3; i++) begin
      r.org[i] = rand_coord();
      r.dir[i] = rand_coord();
      a = rand_coord();
      b = rand_coord();
      if (shaped && a > b) begin r.lo[i] = b; r.hi[i] = a; end
      else begin r.lo[i] = a; r.hi[i] = b; end
      if (shaped && $urandom_range(0, 1)) begin
        r.org[i] = coord_t'($signed($urandom_range(0, 32'h00100000)) - 32'sh00080000);
        r.lo[i] = -coord_t'($urandom_range(1, 32'h00040000));
        r.hi[i] = coord_t'($urandom_range(0, 32'h00040000));
      end
    end
    return r;
  endfunction

  function automatic ray_box_t uniform_ray(coord_t o, coord_t d, coord_t l, coord_t h);
    ray_box_t r;
    for (int i = 0; i < 3; i++) begin
      r.org[i] = o; r.dir[i] = d; r.lo[i] = l; r.hi[i] = h;
    end
    return r;
  endfunction

  initial begin
    ray_box_t r;
    eps_t     eps_set [4];
    eps_set = '{eps_t'(0), eps_t'(32'h7FFFFFFF), eps_t'(32'h00010000), eps_t'(5)};
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed, reset epsilon
    send(uniform_ray(0, 32'sh00010000, -32'sh00010000, 32'sh00010000), 0);
    send(uniform_ray(0, 0, -1, 1), 0);
    send(uniform_ray(5, 0, -1, 1), 0);
    send(uniform_ray(0, 0, 1, -1), 0);
    send(uniform_ray(0, 1, 1, -1), 0);
    send(uniform_ray(T_MIN, 1, T_MAX, T_MAX), 0);
    send(uniform_ray(T_MAX, -1, T_MIN, T_MIN), 0);
    send(uniform_ray(T_MIN, T_MIN, T_MAX, T_MIN), 0);
    send(uniform_ray(T_MAX, T_MAX, T_MIN, T_MAX), 0);
    send(uniform_ray(-1, -1, -1, -1), 0);
    r = uniform_ray(0, 32'sh00010000, 32'sh00010000, 32'sh00020000);
    r.lo[1] = -32'sh00050000; r.hi[1] = -32'sh00040000;
    send(r, 0);
    r = uniform_ray(0, 0, -1, 1);
    r.dir[2] = 32'sh00010000; r.org[1] = 7;
    send(r, 0);
    drain();
    set_epsilon(0);
    send(uniform_ray(0, 0, -1, 1), 0);
    send(uniform_ray(3, 0, -1, 1), 0);
    send(uniform_ray(0, 1, -1, 1), 0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      set_epsilon(ph == 3 ? eps_t'($urandom) : eps_set[ph]);
      for (int k = 0; k < 85; k++) begin
        if (k == 20 && ph == 1) begin
          long_hold_req = 1;
          for (int j = 0; j < 60; j++) send(rand_ray(1), 1);
        end
        if (k == 50) begin
          in_valid <= 0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
        hold_off = (k >= 70 && k < 85);
        send(rand_ray($urandom_range(0, 3) != 0), hold_off);
      end
    end
    hold_off = 0;
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rbsi_pkg.sv
hw/rtl/rbsi_lane.sv
hw/rtl/rbsi_merge.sv
hw/rtl/ray_box_slab_intersection.sv
test/tb_top.sv
